/* sv/camera_trajectory_smoother_assert.svh */
// Assertion macros shared by the smoother modules.
// The module that expands them must have clk and arst_n in scope.
`ifndef CAMERA_TRAJECTORY_SMOOTHER_ASSERT_SVH
`define CAMERA_TRAJECTORY_SMOOTHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smoother check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smoother check failed");

`endif

/* sv/ctsm_pkg.sv */
package ctsm_pkg;

	localparam int PATH_W = 40;
	localparam int SUM_W  = 46;
	localparam int MXY_W  = 24;
	localparam int MA_W   = 20;
	localparam int WIN_W  = 5;
	localparam int CNT_W  = 6;
	localparam int FRM_W  = 32;
	localparam int EXT_W  = 42;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_FIRST  = 1'b1;

	localparam logic signed [PATH_W-1:0] LIM_MAX = {1'b0, {(PATH_W-1){1'b1}}};
	localparam logic signed [PATH_W-1:0] LIM_MIN = {1'b1, {(PATH_W-1){1'b0}}};

	typedef struct packed {
		logic signed [PATH_W-1:0] px;
		logic signed [PATH_W-1:0] py;
		logic signed [PATH_W-1:0] pa;
		logic signed [MXY_W-1:0]  mx;
		logic signed [MXY_W-1:0]  my;
		logic signed [MA_W-1:0]   ma;
	} ring_ent_t;

	typedef struct packed {
		logic      en;
		ring_ent_t data;
	} ring_wr_t;

	typedef struct packed {
		logic [FRM_W-1:0] k0;
		logic [CNT_W-1:0] count;
		logic [FRM_W-1:0] recv;
		logic [WIN_W-1:0] w;
		logic [FRM_W-1:0] first;
		logic             flush;
	} job_t;

	function automatic logic signed [PATH_W-1:0] sat40(input logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		hi = EXT_W'(LIM_MAX);
		lo = EXT_W'(LIM_MIN);
		if (v > hi) return LIM_MAX;
		if (v < lo) return LIM_MIN;
		return v[PATH_W-1:0];
	endfunction

endpackage

/* sv/camera_trajectory_smoother.sv */
// Due frames are smoothed one at a time, over n = 2W+1 window entries at most. The sum over
// the ring (one entry a cycle from one read port) and the bit-serial division set the pace.
// An input frame is taken each cycle the work queue is empty; after a final frame, input holds
// until the flush has been worked off. Reset: window_half 30, first_frame 1, clip cleared,
// rings left undefined (no clearing pass).
module camera_trajectory_smoother #(
	parameter int MAX_HALF_WINDOW = 31,
	parameter int RING_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ctsm_pkg::MXY_W-1:0]  shift_x,
	input  logic signed [ctsm_pkg::MXY_W-1:0]  shift_y,
	input  logic signed [ctsm_pkg::MA_W-1:0]   turn,
	input  logic                               final_frame,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ctsm_pkg::FRM_W-1:0]         frame_index,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_x,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_y,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_angle,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_dx,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_dy,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_da,
	output logic                               flush_end
);
	import ctsm_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	// Front: integrate motion into the trajectory, write both to the rings and
	// decide how many frames are now due; hand that off as one job.
	ring_wr_t      ring_wr;
	logic [AW-1:0] ring_waddr;
	logic          job_valid;
	job_t          job;
	logic [AW-1:0] job_ep;
	logic          bk_idle;

	ctsm_front #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW),
		.RING_DEPTH(RING_DEPTH)
	) u_front (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .shift_x, .shift_y, .turn, .final_frame,
		.ring_wr, .ring_waddr,
		.job_valid, .job, .job_ep, .bk_idle
	);

	// Back: for each due frame, sum the window from the rings, divide by the
	// window count and correct the motion; each result is one output transaction.
	ctsm_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk, .arst_n,
		.ring_wr, .ring_waddr,
		.job_valid, .job, .job_ep, .bk_idle,
		.out_valid, .out_ready,
		.frame_index, .smooth_x, .smooth_y, .smooth_angle,
		.fixed_dx, .fixed_dy, .fixed_da, .flush_end
	);

endmodule

/* sv/ctsm_div.sv */
module ctsm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ctsm_pkg::SUM_W-1:0]   dividend,
	input  logic [ctsm_pkg::CNT_W-1:0]          divisor,
	output logic                                busy,
	output logic signed [ctsm_pkg::PATH_W-1:0]  quotient
);
	import ctsm_pkg::*;

	logic [SUM_W-1:0] mag_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [CNT_W:0]   trial;
	logic             ge;
	logic [SUM_W-1:0] q_full;

	assign trial  = {rem_q, mag_q[SUM_W-1]};
	assign ge     = trial >= {1'b0, dvs_q};
	assign busy   = cnt_q != '0;
	assign q_full = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = q_full[PATH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[SUM_W-1];
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], ge};
		end
	end

endmodule

/* sv/ctsm_front.sv */
`include "camera_trajectory_smoother_assert.svh"

module ctsm_front #(
	parameter int MAX_HALF_WINDOW = 31,
	parameter int RING_DEPTH = 64,
	localparam int AW = $clog2(RING_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ctsm_pkg::MXY_W-1:0] shift_x,
	input  logic signed [ctsm_pkg::MXY_W-1:0] shift_y,
	input  logic signed [ctsm_pkg::MA_W-1:0]  turn,
	input  logic                              final_frame,
	output ctsm_pkg::ring_wr_t                ring_wr,
	output logic [AW-1:0]                     ring_waddr,
	output logic                              job_valid,
	output ctsm_pkg::job_t                    job,
	output logic [AW-1:0]                     job_ep,
	input  logic                              bk_idle
);
	import ctsm_pkg::*;

	localparam int WCAP_R = (RING_DEPTH - 1) / 2;
	localparam int WCAP   = (MAX_HALF_WINDOW < WCAP_R) ? MAX_HALF_WINDOW : WCAP_R;
	localparam int CAP    = MAX_HALF_WINDOW + 1;
	localparam int EW     = CNT_W + 1;

	logic [WIN_W-1:0]         win_q;
	logic [FRM_W-1:0]         first_q;
	logic signed [PATH_W-1:0] run_x_q, run_y_q, run_a_q;
	logic [FRM_W-1:0]         recv_q, emit_q;
	logic [AW-1:0]            wpos_q, epos_q;
	logic                     job_valid_q, last_hold_q;
	job_t                     job_q;
	logic [AW-1:0]            job_ep_q;

	logic                     accept;
	logic [WIN_W-1:0]         w_eff;
	logic signed [PATH_W-1:0] nx, ny, na;
	logic [FRM_W-1:0]         recv1, pend, diff;
	logic [CNT_W-1:0]         cnt;
	logic [EW-1:0]            ep_sum;
	logic [AW-1:0]            epos_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = !job_valid_q && !last_hold_q;
	assign accept    = in_valid && in_ready;

	assign w_eff = (win_q > WIN_W'(WCAP)) ? WIN_W'(WCAP) : win_q;
	assign nx    = sat40(EXT_W'(run_x_q) + EXT_W'(shift_x));
	assign ny    = sat40(EXT_W'(run_y_q) + EXT_W'(shift_y));
	assign na    = sat40(EXT_W'(run_a_q) + EXT_W'(turn));
	assign recv1 = recv_q + 1'b1;
	assign pend  = recv1 - emit_q;
	assign diff  = pend - FRM_W'(w_eff);

	always_comb begin
		cnt = '0;
		if (final_frame) begin
			cnt = (pend > FRM_W'(CAP)) ? CNT_W'(CAP) : pend[CNT_W-1:0];
		end else if ((pend - 1'b1) >= FRM_W'(w_eff)) begin
			cnt = (diff > FRM_W'(CAP)) ? CNT_W'(CAP) : diff[CNT_W-1:0];
		end
	end

	assign ep_sum  = EW'(epos_q) + EW'(cnt);
	assign epos_nx = (ep_sum >= EW'(RING_DEPTH)) ? AW'(ep_sum - EW'(RING_DEPTH)) : AW'(ep_sum);

	assign ring_wr.en        = accept;
	assign ring_wr.data.px   = nx;
	assign ring_wr.data.py   = ny;
	assign ring_wr.data.pa   = na;
	assign ring_wr.data.mx   = shift_x;
	assign ring_wr.data.my   = shift_y;
	assign ring_wr.data.ma   = turn;
	assign ring_waddr        = wpos_q;
	assign job_valid         = job_valid_q;
	assign job               = job_q;
	assign job_ep            = job_ep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_W'(30);
			first_q     <= FRM_W'(1);
			run_x_q     <= '0;
			run_y_q     <= '0;
			run_a_q     <= '0;
			recv_q      <= '0;
			emit_q      <= '0;
			wpos_q      <= '0;
			epos_q      <= '0;
			job_valid_q <= 1'b0;
			last_hold_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WINDOW: win_q   <= cfg_data[WIN_W-1:0];
					CFG_FIRST:  first_q <= cfg_data;
					default:    ;
				endcase
			end
			if (job_valid_q && bk_idle) begin
				job_valid_q <= 1'b0;
			end
			if (accept && final_frame) begin
				last_hold_q <= 1'b1;
			end else if (!job_valid_q && bk_idle) begin
				last_hold_q <= 1'b0;
			end
			if (accept) begin
				if (cnt != '0) begin
					job_valid_q <= 1'b1;
				end
				if (final_frame) begin
					run_x_q <= '0;
					run_y_q <= '0;
					run_a_q <= '0;
					recv_q  <= '0;
					emit_q  <= '0;
					wpos_q  <= '0;
					epos_q  <= '0;
				end else begin
					run_x_q <= nx;
					run_y_q <= ny;
					run_a_q <= na;
					recv_q  <= recv1;
					emit_q  <= emit_q + FRM_W'(cnt);
					wpos_q  <= (wpos_q == AW'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
					epos_q  <= epos_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.k0    <= emit_q;
			job_q.count <= cnt;
			job_q.recv  <= recv1;
			job_q.w     <= w_eff;
			job_q.first <= first_q;
			job_q.flush <= final_frame && (FRM_W'(cnt) == pend);
			job_ep_q    <= epos_q;
		end
	end

	`CTS_ASSERT_NEXT(a_last_clears, accept && final_frame, recv_q == '0 && emit_q == '0)
	`CTS_ASSERT_NEXT(a_slot_holds, job_valid_q && !bk_idle, job_valid_q)
	`CTS_ASSERT_NOW(a_no_overrun, job_valid_q, FRM_W'(job_q.count) <= job_q.recv - job_q.k0)

endmodule

/* sv/ctsm_back.sv */
`include "camera_trajectory_smoother_assert.svh"

module ctsm_back #(
	parameter int RING_DEPTH = 64,
	localparam int AW = $clog2(RING_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ctsm_pkg::ring_wr_t                 ring_wr,
	input  logic [AW-1:0]                      ring_waddr,
	input  logic                               job_valid,
	input  ctsm_pkg::job_t                     job,
	input  logic [AW-1:0]                      job_ep,
	output logic                               bk_idle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ctsm_pkg::FRM_W-1:0]         frame_index,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_x,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_y,
	output logic signed [ctsm_pkg::PATH_W-1:0] smooth_angle,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_dx,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_dy,
	output logic signed [ctsm_pkg::PATH_W-1:0] fixed_da,
	output logic                               flush_end
);
	import ctsm_pkg::*;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SETUP = 3'd1;
	localparam logic [2:0] B_SUM   = 3'd2;
	localparam logic [2:0] B_SUMW  = 3'd3;
	localparam logic [2:0] B_AT    = 3'd4;
	localparam logic [2:0] B_DIVW  = 3'd5;
	localparam logic [2:0] B_FIX   = 3'd6;

	ring_ent_t ring_mem [RING_DEPTH];
	ring_ent_t rd_q;

	logic [2:0]              state_q;
	logic [FRM_W-1:0]        k_q, recv_q, fnum_q;
	logic [CNT_W-1:0]        left_q, issue_q, n_q;
	logic [WIN_W-1:0]        w_q;
	logic [AW-1:0]           at_q, idx_q;
	logic                    flush_q;
	logic                    sum_tag_s1;
	logic signed [SUM_W-1:0] acc_x_q, acc_y_q, acc_a_q;
	ring_ent_t               at_ent_q;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [WIN_W-1:0]        lo, hi;
	logic [FRM_W-1:0]        d;
	logic [AW:0]             st_tmp;
	logic [AW-1:0]           st_idx;
	logic                    div_start;
	logic                    bx, by, ba;
	logic signed [PATH_W-1:0] qx, qy, qa;
	logic                    load;

	assign bk_idle = state_q == B_IDLE;

	assign lo     = (k_q < FRM_W'(w_q)) ? k_q[WIN_W-1:0] : w_q;
	assign d      = recv_q - 1'b1 - k_q;
	assign hi     = (d < FRM_W'(w_q)) ? d[WIN_W-1:0] : w_q;
	assign st_tmp = {1'b0, at_q} + (AW+1)'(RING_DEPTH) - (AW+1)'(lo);
	assign st_idx = (st_tmp >= (AW+1)'(RING_DEPTH)) ? AW'(st_tmp - (AW+1)'(RING_DEPTH))
		: AW'(st_tmp);

	assign rd_en     = (state_q == B_SUM) || (state_q == B_SUMW);
	assign rd_addr   = (state_q == B_SUM) ? idx_q : at_q;
	assign div_start = state_q == B_AT;
	assign load      = (state_q == B_FIX) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (ring_wr.en) begin
			ring_mem[ring_waddr] <= ring_wr.data;
		end
		if (rd_en) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	ctsm_div u_div_x (.clk, .arst_n, .start(div_start), .dividend(acc_x_q), .divisor(n_q),
		.busy(bx), .quotient(qx));
	ctsm_div u_div_y (.clk, .arst_n, .start(div_start), .dividend(acc_y_q), .divisor(n_q),
		.busy(by), .quotient(qy));
	ctsm_div u_div_a (.clk, .arst_n, .start(div_start), .dividend(acc_a_q), .divisor(n_q),
		.busy(ba), .quotient(qa));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			sum_tag_s1 <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			sum_tag_s1 <= state_q == B_SUM;
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE:  if (job_valid) state_q <= B_SETUP;
				B_SETUP: state_q <= B_SUM;
				B_SUM:   if (issue_q == CNT_W'(1)) state_q <= B_SUMW;
				B_SUMW:  state_q <= B_AT;
				B_AT:    state_q <= B_DIVW;
				B_DIVW:  if (!bx) state_q <= B_FIX;
				B_FIX:   if (load) state_q <= (left_q == CNT_W'(1)) ? B_IDLE : B_SETUP;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sum_tag_s1) begin
			acc_x_q <= acc_x_q + SUM_W'(rd_q.px);
			acc_y_q <= acc_y_q + SUM_W'(rd_q.py);
			acc_a_q <= acc_a_q + SUM_W'(rd_q.pa);
		end
		unique case (state_q)
			B_IDLE: begin
				k_q     <= job.k0;
				left_q  <= job.count;
				recv_q  <= job.recv;
				w_q     <= job.w;
				fnum_q  <= job.first + job.k0;
				flush_q <= job.flush;
				at_q    <= job_ep;
			end
			B_SETUP: begin
				n_q     <= CNT_W'(lo) + CNT_W'(hi) + 1'b1;
				issue_q <= CNT_W'(lo) + CNT_W'(hi) + 1'b1;
				idx_q   <= st_idx;
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_a_q <= '0;
			end
			B_SUM: begin
				issue_q <= issue_q - 1'b1;
				idx_q   <= (idx_q == AW'(RING_DEPTH - 1)) ? '0 : idx_q + 1'b1;
			end
			B_AT: at_ent_q <= rd_q;
			B_FIX: begin
				if (load) begin
					k_q    <= k_q + 1'b1;
					fnum_q <= fnum_q + 1'b1;
					left_q <= left_q - 1'b1;
					at_q   <= (at_q == AW'(RING_DEPTH - 1)) ? '0 : at_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result register: the next frame works on while this one waits
	always_ff @(posedge clk) begin
		if (load) begin
			frame_index  <= fnum_q;
			smooth_x     <= qx;
			smooth_y     <= qy;
			smooth_angle <= qa;
			fixed_dx     <= sat40(EXT_W'(at_ent_q.mx) + EXT_W'(qx) - EXT_W'(at_ent_q.px));
			fixed_dy     <= sat40(EXT_W'(at_ent_q.my) + EXT_W'(qy) - EXT_W'(at_ent_q.py));
			fixed_da     <= sat40(EXT_W'(at_ent_q.ma) + EXT_W'(qa) - EXT_W'(at_ent_q.pa));
			flush_end    <= flush_q && (left_q == CNT_W'(1));
		end
	end

	`CTS_ASSERT_NEXT(a_take_job, state_q == B_IDLE && job_valid, state_q == B_SETUP)
	`CTS_ASSERT_NOW(a_sum_count, state_q == B_SUM, issue_q != '0)
	`CTS_ASSERT_NOW(a_divs_lockstep, state_q == B_DIVW, bx == by && by == ba)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ctsm_pkg::*;

	// One smoothed frame as it leaves the block.
	typedef struct {
		logic [FRM_W-1:0]         frame;
		logic signed [PATH_W-1:0] sx;
		logic signed [PATH_W-1:0] sy;
		logic signed [PATH_W-1:0] sa;
		logic signed [PATH_W-1:0] fx;
		logic signed [PATH_W-1:0] fy;
		logic signed [PATH_W-1:0] fa;
		logic                     last;
	} smoothed_frame_t;

	// Trajectory predictor: keeps its own copy of the clip state and registers,
	// queues the smoothed frames each accepted input frame releases and checks
	// every output transaction against the oldest one.
	class trajectory_predictor;
		longint          path_x[64], path_y[64], path_a[64];
		longint          mot_x[64], mot_y[64], mot_a[64];
		longint          run_x, run_y, run_a;
		int unsigned     received, emitted;
		int unsigned     half_win, first_num;
		smoothed_frame_t pending_results[$];
		int              errors, results_seen, frames_seen;

		function new();
			half_win = 30;
			first_num = 1;
		endfunction

		function void set_register(logic idx, logic [31:0] val);
			if (idx == CFG_WINDOW)
				half_win = val & 31;
			else
				first_num = val;
		endfunction

		function longint clamp40(longint v);
			longint hi, lo;
			hi = (longint'(1) <<< 39) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		// Average over the truncated window centred on the oldest pending frame.
		function void release_oldest(int unsigned w);
			smoothed_frame_t r;
			int unsigned k, d, lo, hi, n, at, idx;
			longint sx, sy, sa, ax, ay, aa;
			k = emitted;
			d = received - 1 - k;
			lo = (k < w) ? k : w;
			hi = (d < w) ? d : w;
			n = lo + hi + 1;
			at = k % 64;
			sx = 0; sy = 0; sa = 0;
			for (int unsigned j = 0; j < n; j++) begin
				idx = (k - lo + j) % 64;
				sx += path_x[idx];
				sy += path_y[idx];
				sa += path_a[idx];
			end
			ax = sx / longint'(n);
			ay = sy / longint'(n);
			aa = sa / longint'(n);
			r.frame = first_num + k;
			r.sx = ax[PATH_W-1:0];
			r.sy = ay[PATH_W-1:0];
			r.sa = aa[PATH_W-1:0];
			r.fx = PATH_W'(clamp40(mot_x[at] + ax - path_x[at]));
			r.fy = PATH_W'(clamp40(mot_y[at] + ay - path_y[at]));
			r.fa = PATH_W'(clamp40(mot_a[at] + aa - path_a[at]));
			r.last = 1'b0;
			pending_results.insert(pending_results.size(), r);
			emitted++;
		endfunction

		function void note_frame(logic signed [MXY_W-1:0] x, logic signed [MXY_W-1:0] y,
				logic signed [MA_W-1:0] a, logic last);
			int unsigned w, pos, pend;
			int count;
			w = (half_win > 31) ? 31 : half_win;
			pos = received % 64;
			count = 0;
			frames_seen++;
			run_x = clamp40(run_x + x);
			run_y = clamp40(run_y + y);
			run_a = clamp40(run_a + a);
			path_x[pos] = run_x;
			path_y[pos] = run_y;
			path_a[pos] = run_a;
			mot_x[pos] = x;
			mot_y[pos] = y;
			mot_a[pos] = a;
			received++;
			while (count < 32) begin
				pend = received - emitted;
				if (pend == 0) break;
				if (!last && pend - 1 < w) break;
				release_oldest(w);
				count++;
			end
			if (last) begin
				// flag the clip's closing frame only if the flush emptied the clip
				if (count > 0 && received == emitted)
					pending_results[$].last = 1'b1;
				run_x = 0; run_y = 0; run_a = 0;
				received = 0; emitted = 0;
			end
		endfunction

		function void compare(string field, logic [PATH_W-1:0] exp_v, logic [PATH_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(smoothed_frame_t got);
			smoothed_frame_t e;
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result for frame %0d, expected none, actual one",
					$time, got.frame);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare("frame_index", PATH_W'(e.frame), PATH_W'(got.frame));
			compare("smooth_x", e.sx, got.sx);
			compare("smooth_y", e.sy, got.sy);
			compare("smooth_angle", e.sa, got.sa);
			compare("fixed_dx", e.fx, got.fx);
			compare("fixed_dy", e.fy, got.fy);
			compare("fixed_da", e.fa, got.fa);
			compare("flush_end", PATH_W'(e.last), PATH_W'(got.last));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid, cfg_ready, cfg_index;
	logic [31:0]              cfg_data;
	logic                     in_valid, in_ready;
	logic signed [MXY_W-1:0]  shift_x, shift_y;
	logic signed [MA_W-1:0]   turn;
	logic                     final_frame;
	logic                     out_valid, out_ready;
	logic [FRM_W-1:0]         frame_index;
	logic signed [PATH_W-1:0] smooth_x, smooth_y, smooth_angle;
	logic signed [PATH_W-1:0] fixed_dx, fixed_dy, fixed_da;
	logic                     flush_end;

	trajectory_predictor sb = new();
	bit                  quiet;     // no idling in the closing stretch
	int                  clips;
	int                  stall_left;

	camera_trajectory_smoother u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.shift_x(shift_x), .shift_y(shift_y), .turn(turn), .final_frame(final_frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_index(frame_index), .smooth_x(smooth_x), .smooth_y(smooth_y),
		.smooth_angle(smooth_angle), .fixed_dx(fixed_dx), .fixed_dy(fixed_dy),
		.fixed_da(fixed_da), .flush_end(flush_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver side: stall in short bursts, never in the closing stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Sample each output transaction with pre-edge values and check it.
	always @(posedge clk) begin
		smoothed_frame_t r;
		if (arst_n && out_valid && out_ready) begin
			r.frame = frame_index;
			r.sx = smooth_x;
			r.sy = smooth_y;
			r.sa = smooth_angle;
			r.fx = fixed_dx;
			r.fy = fixed_dy;
			r.fa = fixed_da;
			r.last = flush_end;
			sb.check_result(r);
		end
	end

	// Hold the register write until its transaction, then drop valid for a cycle.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one frame; an optional short gap goes in front of it.
	task automatic send_frame(input logic signed [MXY_W-1:0] x, input logic signed [MXY_W-1:0] y,
			input logic signed [MA_W-1:0] a, input logic last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		shift_x <= x;
		shift_y <= y;
		turn <= a;
		final_frame <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_frame(x, y, a, last);
	endtask

	// Wait for every expected result, then let the block finish any internal work.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Mix of extremes, small steps and full-range values for a w-bit signed field.
	function automatic logic [23:0] pick(input int w);
		logic [23:0] v;
		case ($urandom_range(0, 5))
			0: v = (24'd1 << (w - 1)) - 24'd1;
			1: v = ~((24'd1 << (w - 1)) - 24'd1);
			2, 3: v = 24'($urandom_range(0, 1024)) - 24'd512;
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_clip(input int len);
		for (int i = 0; i < len; i++)
			send_frame(pick(24), pick(24), 20'(pick(20)), i == len - 1);
		clips++;
		settle();
	endtask

	initial begin
		int done_items;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_WINDOW; cfg_data = '0;
		in_valid = 1'b0; shift_x = '0; shift_y = '0; turn = '0; final_frame = 1'b0;
		quiet = 1'b0;
		clips = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// Reset settings: a one-frame clip at the positive extremes.
		send_frame(24'sh7FFFFF, 24'sh7FFFFF, 20'sh7FFFF, 1'b1);
		clips++;
		settle();

		// Zero window from frame 0: each frame averages over itself only.
		write_reg(CFG_WINDOW, 32'd0);
		write_reg(CFG_FIRST, 32'd0);
		send_frame(24'sh800000, 24'sh7FFFFF, 20'sh80000, 1'b0);
		send_frame(24'sh800000, 24'sh800000, 20'sh7FFFF, 1'b0);
		send_frame(-24'sd1, 24'sd1, -20'sd1, 1'b1);
		clips++;
		settle();

		// Widest window with frame numbers wrapping past the top.
		write_reg(CFG_WINDOW, 32'd31);
		write_reg(CFG_FIRST, 32'hFFFF_FFFE);
		send_frame(24'sh7FFFFF, 24'sh800000, 20'sh7FFFF, 1'b0);
		send_frame(24'sh000101, -24'sd3, 20'sd7, 1'b0);
		send_frame(-24'sd5, 24'sh7FFFFF, 20'sh80000, 1'b0);
		send_frame(24'sd0, 24'sd0, 20'sd0, 1'b0);
		send_frame(24'sh800000, 24'sh123456, -20'sd100, 1'b1);
		clips++;
		settle();

		// Shrink the window partway through a clip: due frames go out at once.
		write_reg(CFG_WINDOW, 32'd4);
		write_reg(CFG_FIRST, 32'd100);
		for (int i = 0; i < 4; i++)
			send_frame(pick(24), pick(24), 20'(pick(20)), 1'b0);
		settle();
		write_reg(CFG_WINDOW, 32'd1);
		send_frame(24'sd77, -24'sd77, 20'sd9, 1'b0);
		send_frame(-24'sd3, 24'sd8, -20'sd2, 1'b1);
		clips++;
		settle();

		// A clip longer than the rings, to wrap the ring pointers.
		write_reg(CFG_WINDOW, 32'd3);
		write_reg(CFG_FIRST, $urandom);
		send_clip(70);

		// Random clips with random settings; the tail runs without idling.
		done_items = 0;
		while (done_items < 20) begin
			int len;
			if (done_items >= 10) quiet = 1'b1;
			write_reg(CFG_WINDOW, ($urandom_range(0, 3) == 0) ? 32'd31 : $urandom_range(0, 8));
			write_reg(CFG_FIRST, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
			len = $urandom_range(1, 8);
			send_clip(len);
			done_items += len;
		end

		$display("Covered %0d clips, %0d frames in and %0d smoothed frames out,",
			clips, sb.frames_seen, sb.results_seen);
		$display("windows from 0 to 31, wrapping frame numbers and mid-clip window changes.");
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("[camera_trajectory_smoother] OK");
		else
			$display("[camera_trajectory_smoother] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("[camera_trajectory_smoother] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/ctsm_pkg.sv
sv/ctsm_div.sv
sv/ctsm_front.sv
sv/ctsm_back.sv
sv/camera_trajectory_smoother.sv
tb/tb.sv
